/* sv/pdmcs_pkg.sv */
`default_nettype none

package pdmcs_pkg;

    localparam int VEL_FRAC_BITS_DEF = 8;
    localparam int POSITION_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [11:0] KP_FAR_RST   = 12'd49;
    localparam logic [11:0] KP_NEAR_RST  = 12'd29;
    localparam logic [11:0] KD_BASE_RST  = 12'd163;
    localparam logic [9:0]  KD_SLOPE_RST = 10'd123;
    localparam logic [15:0] NEAR_WIN_RST = 16'd40;
    localparam logic [8:0]  ALPHA_RST    = 9'd51;
    localparam logic [10:0] FRAME_ID_RST = 11'd1;

    localparam logic [8:0]  ALPHA_ONE    = 9'd256;
    localparam logic [11:0] ZERO_CODE12  = 12'd2047;
    localparam logic [11:0] KD_MAX       = 12'd4095;
    localparam logic [63:0] ENABLE_FRAME = 64'hFFFF_FFFF_FFFF_FFFC;

    typedef enum logic [1:0] {
        REQ_REPLY  = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_HOME   = 2'd2,
        REQ_ENABLE = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_FAR   = 3'd0,
        CFG_KP_NEAR  = 3'd1,
        CFG_KD_BASE  = 3'd2,
        CFG_KD_SLOPE = 3'd3,
        CFG_NEAR_WIN = 3'd4,
        CFG_ALPHA    = 3'd5,
        CFG_FRAME_ID = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_NEW,
        ST_MUL_OLD,
        ST_FILT,
        ST_MUL_KD,
        ST_EMIT_TICK,
        ST_EMIT_EN
    } t_state;

    typedef enum logic [1:0] {
        MUL_NEW,
        MUL_OLD,
        MUL_KD
    } t_mul_sel;

    typedef struct packed {
        logic [11:0] kp_far;
        logic [11:0] kp_near;
        logic [11:0] kd_base;
        logic [9:0]  kd_slope;
        logic [15:0] near_window;
        logic [8:0]  alpha;
        logic [10:0] frame_id;
    } t_cfg;

    typedef struct packed {
        logic     accept;
        t_req     req;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_en;
        logic     filt_en;
        logic     load_tick;
        logic     load_enable;
    } t_dp_cmd;

endpackage

`default_nettype wire

/* sv/pdmcs_cfg.sv */
`default_nettype none

module pdmcs_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [pdmcs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pdmcs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output pdmcs_pkg::t_cfg                       o_cfg
);

    pdmcs_pkg::t_cfg r_cfg;
    pdmcs_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (pdmcs_pkg::t_cfg_idx'(i_cfg_index))
                pdmcs_pkg::CFG_KP_FAR:   n_cfg.kp_far      = i_cfg_data[11:0];
                pdmcs_pkg::CFG_KP_NEAR:  n_cfg.kp_near     = i_cfg_data[11:0];
                pdmcs_pkg::CFG_KD_BASE:  n_cfg.kd_base     = i_cfg_data[11:0];
                pdmcs_pkg::CFG_KD_SLOPE: n_cfg.kd_slope    = i_cfg_data[9:0];
                pdmcs_pkg::CFG_NEAR_WIN: n_cfg.near_window = i_cfg_data[15:0];
                pdmcs_pkg::CFG_ALPHA:    n_cfg.alpha       = i_cfg_data[8:0];
                pdmcs_pkg::CFG_FRAME_ID: n_cfg.frame_id    = i_cfg_data[10:0];
                default:                 n_cfg             = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_far      <= pdmcs_pkg::KP_FAR_RST;
            r_cfg.kp_near     <= pdmcs_pkg::KP_NEAR_RST;
            r_cfg.kd_base     <= pdmcs_pkg::KD_BASE_RST;
            r_cfg.kd_slope    <= pdmcs_pkg::KD_SLOPE_RST;
            r_cfg.near_window <= pdmcs_pkg::NEAR_WIN_RST;
            r_cfg.alpha       <= pdmcs_pkg::ALPHA_RST;
            r_cfg.frame_id    <= pdmcs_pkg::FRAME_ID_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

/* sv/pdmcs_ctrl.sv */
`default_nettype none

module pdmcs_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  pdmcs_pkg::t_req      i_in_req,
    output logic                 o_in_ready,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output pdmcs_pkg::t_dp_cmd   o_cmd
);

    pdmcs_pkg::t_state r_state;
    pdmcs_pkg::t_state n_state;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state           = r_state;
        o_in_ready        = 1'b0;
        o_cmd.accept      = 1'b0;
        o_cmd.req         = i_in_req;
        o_cmd.mul_en      = 1'b0;
        o_cmd.mul_sel     = pdmcs_pkg::MUL_NEW;
        o_cmd.acc_en      = 1'b0;
        o_cmd.filt_en     = 1'b0;
        o_cmd.load_tick   = 1'b0;
        o_cmd.load_enable = 1'b0;
        unique case (r_state)
            pdmcs_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    case (i_in_req)
                        pdmcs_pkg::REQ_TICK:   n_state = pdmcs_pkg::ST_MUL_NEW;
                        pdmcs_pkg::REQ_ENABLE: n_state = pdmcs_pkg::ST_EMIT_EN;
                        default:               n_state = pdmcs_pkg::ST_IDLE;
                    endcase
                end
            end
            pdmcs_pkg::ST_MUL_NEW: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = pdmcs_pkg::MUL_NEW;
                n_state       = pdmcs_pkg::ST_MUL_OLD;
            end
            pdmcs_pkg::ST_MUL_OLD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = pdmcs_pkg::MUL_OLD;
                o_cmd.acc_en  = 1'b1;
                n_state       = pdmcs_pkg::ST_FILT;
            end
            pdmcs_pkg::ST_FILT: begin
                o_cmd.filt_en = 1'b1;
                n_state       = pdmcs_pkg::ST_MUL_KD;
            end
            pdmcs_pkg::ST_MUL_KD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = pdmcs_pkg::MUL_KD;
                n_state       = pdmcs_pkg::ST_EMIT_TICK;
            end
            pdmcs_pkg::ST_EMIT_TICK: begin
                if (out_free) begin
                    o_cmd.load_tick = 1'b1;
                    n_state         = pdmcs_pkg::ST_IDLE;
                end
            end
            pdmcs_pkg::ST_EMIT_EN: begin
                if (out_free) begin
                    o_cmd.load_enable = 1'b1;
                    n_state           = pdmcs_pkg::ST_IDLE;
                end
            end
            default: n_state = pdmcs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_tick || o_cmd.load_enable) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pdmcs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* sv/pdmcs_dp.sv */
`default_nettype none

module pdmcs_dp #(
    parameter int VEL_FRAC_BITS = pdmcs_pkg::VEL_FRAC_BITS_DEF,
    parameter int POSITION_BITS = pdmcs_pkg::POSITION_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  pdmcs_pkg::t_dp_cmd i_cmd,
    input  pdmcs_pkg::t_cfg    i_cfg,
    input  wire logic [63:0]   i_reply,
    output logic [63:0]        o_frame,
    output logic [10:0]        o_std_id
);

    localparam int FW      = 13 + VEL_FRAC_BITS;
    localparam int PW      = 11 + FW;
    localparam int KSH     = 8 + VEL_FRAC_BITS;
    localparam int ADD_W   = PW - KSH;
    localparam int POS_SH  = 16 - POSITION_BITS;
    localparam logic [POSITION_BITS-1:0] POS_MID = {1'b1, {(POSITION_BITS-1){1'b0}}};

    logic        [POSITION_BITS-1:0] r_last_pos;
    logic        [POSITION_BITS-1:0] r_hold_pos;
    logic signed [12:0]              r_vel_half;
    logic signed [FW-1:0]            r_filt;
    logic signed [PW-1:0]            r_prod;
    logic signed [PW-1:0]            r_acc;
    logic        [63:0]              r_out_frame;
    logic        [10:0]              r_out_id;

    logic        [8:0]               alpha_c;
    logic        [9:0]               mul_a;
    logic signed [FW-1:0]            mul_b;
    logic signed [PW-1:0]            mul_p;
    logic signed [FW-1:0]            vel_q;
    logic signed [FW-1:0]            filt_abs;
    logic signed [PW-1:0]            sum;
    logic signed [13:0]              vel_wide;
    logic signed [POSITION_BITS:0]   pos_err;
    logic        [POSITION_BITS-1:0] pos_mag;
    logic        [11:0]              kp_sel;
    logic        [ADD_W-1:0]         kd_add;
    logic        [ADD_W:0]           kd_sum;
    logic        [11:0]              kd_sat;
    logic        [15:0]              pos_field;

    assign alpha_c  = (i_cfg.alpha > pdmcs_pkg::ALPHA_ONE) ? pdmcs_pkg::ALPHA_ONE : i_cfg.alpha;
    assign vel_q    = {r_vel_half, {VEL_FRAC_BITS{1'b0}}};
    assign filt_abs = r_filt[FW-1] ? -r_filt : r_filt;

    always_comb begin
        case (i_cmd.mul_sel)
            pdmcs_pkg::MUL_NEW: begin
                mul_a = {1'b0, alpha_c};
                mul_b = vel_q;
            end
            pdmcs_pkg::MUL_OLD: begin
                mul_a = {1'b0, pdmcs_pkg::ALPHA_ONE - alpha_c};
                mul_b = r_filt;
            end
            default: begin
                mul_a = i_cfg.kd_slope;
                mul_b = filt_abs;
            end
        endcase
    end

    assign mul_p    = PW'($signed({1'b0, mul_a})) * PW'(mul_b);
    assign sum      = r_acc + r_prod + PW'(128);
    assign vel_wide = $signed({1'b0, i_reply[39:28], 1'b0}) - 14'sd4095;

    assign pos_err  = $signed({1'b0, r_hold_pos}) - $signed({1'b0, r_last_pos});
    assign pos_mag  = pos_err[POSITION_BITS] ? POSITION_BITS'(-pos_err)
                                             : pos_err[POSITION_BITS-1:0];
    assign kp_sel   = (16'(pos_mag) < i_cfg.near_window) ? i_cfg.kp_near : i_cfg.kp_far;
    assign kd_add   = r_prod[PW-1:KSH];
    assign kd_sum   = (ADD_W+1)'(i_cfg.kd_base) + (ADD_W+1)'(kd_add);
    assign kd_sat   = (kd_sum > (ADD_W+1)'(pdmcs_pkg::KD_MAX)) ? pdmcs_pkg::KD_MAX
                                                               : kd_sum[11:0];
    assign pos_field = 16'(r_hold_pos) << POS_SH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pos <= POS_MID;
            r_hold_pos <= POS_MID;
            r_vel_half <= '0;
            r_filt     <= '0;
        end else begin
            if (i_cmd.accept && i_cmd.req == pdmcs_pkg::REQ_REPLY) begin
                r_last_pos <= i_reply[55:56-POSITION_BITS];
                r_vel_half <= vel_wide[12:0];
            end
            if (i_cmd.accept && i_cmd.req == pdmcs_pkg::REQ_HOME) begin
                r_hold_pos <= r_last_pos;
            end
            if (i_cmd.filt_en) begin
                r_filt <= FW'(sum >>> 8);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.acc_en) begin
            r_acc <= r_prod;
        end
        if (i_cmd.load_tick) begin
            r_out_frame <= {pos_field, pdmcs_pkg::ZERO_CODE12, kp_sel, kd_sat,
                            pdmcs_pkg::ZERO_CODE12};
            r_out_id    <= i_cfg.frame_id;
        end else if (i_cmd.load_enable) begin
            r_out_frame <= pdmcs_pkg::ENABLE_FRAME;
            r_out_id    <= i_cfg.frame_id;
        end
    end

    assign o_frame  = r_out_frame;
    assign o_std_id = r_out_id;

endmodule

`default_nettype wire

/* sv/pd_motor_command_scheduler_top.sv */
// Reply and capture-home requests produce no output. An enable request passes through
// ST_EMIT_EN and a control tick through ST_MUL_NEW, ST_MUL_OLD, ST_FILT, ST_MUL_KD and
// ST_EMIT_TICK before its frame is registered; no new request is taken until ST_IDLE.
// The tick path runs three products through one shared multiplier, one per multiply state.
// A result waiting at the output holds back the next result, and with it the next request.
// Synchronous active-low reset restores the default registers and the home and filter state.
`default_nettype none

module pd_motor_command_scheduler_top #(
    parameter int VEL_FRAC_BITS = pdmcs_pkg::VEL_FRAC_BITS_DEF,
    parameter int POSITION_BITS = pdmcs_pkg::POSITION_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [63:0]                      i_s_axis_tdata,  // [63:0] reply_frame
    input  wire logic [1:0]                       i_s_axis_tuser,  // [1:0] req_type
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic [79:0]                           o_m_axis_tdata,  // [63:0] frame_bytes,
                                                                   // [74:64] frame_std_id
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [pdmcs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pdmcs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    pdmcs_pkg::t_cfg    cfg;
    pdmcs_pkg::t_dp_cmd cmd;
    logic [63:0]        frame;
    logic [10:0]        std_id;

    pdmcs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pdmcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_req    (pdmcs_pkg::t_req'(i_s_axis_tuser)),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd)
    );

    pdmcs_dp #(
        .VEL_FRAC_BITS (VEL_FRAC_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_cfg    (cfg),
        .i_reply  (i_s_axis_tdata),
        .o_frame  (frame),
        .o_std_id (std_id)
    );

    assign o_m_axis_tdata = {5'd0, std_id, frame};

endmodule

`default_nettype wire

/* sv/pdmcs_checker.sv */
`default_nettype none

module pdmcs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [1:0]  i_s_axis_tuser,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [79:0] o_m_axis_tdata
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output request changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // Every frame is either the enable frame or a command with zero velocity and torque codes.
    a_frame_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[63:0] == pdmcs_pkg::ENABLE_FRAME) ||
            (o_m_axis_tdata[47:36] == pdmcs_pkg::ZERO_CODE12 &&
             o_m_axis_tdata[11:0] == pdmcs_pkg::ZERO_CODE12))
        else $error("malformed command frame");

    // A control tick occupies the datapath, so no request is taken in the next cycle.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == pdmcs_pkg::REQ_TICK
            |=> !o_s_axis_tready)
        else $error("request taken while a tick is in progress");

endmodule

bind pd_motor_command_scheduler_top pdmcs_checker u_pdmcs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

/* test/testbench.sv */
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_SHIFT = 16 - pdmcs_pkg::POSITION_BITS_DEF;
    localparam int KD_SHIFT  = 8 + pdmcs_pkg::VEL_FRAC_BITS_DEF;

    typedef struct {
        logic [63:0] bytes;
        logic [10:0] std_id;
    } t_cmd_frame;

    // Keeps a copy of the gain registers and the motor state, and works out
    // the command frame that each request should produce.
    class command_frame_board;
        logic [11:0] kp_far, kp_near, kd_base;
        logic [9:0]  kd_slope;
        logic [15:0] near_win;
        logic [8:0]  alpha;
        logic [10:0] frame_id;
        logic [15:0] last_pos, hold_pos;
        int          vel_half;
        longint      vel_avg;
        t_cmd_frame  pending_frames[$];
        int          mismatches;

        function new();
            kp_far     = pdmcs_pkg::KP_FAR_RST;
            kp_near    = pdmcs_pkg::KP_NEAR_RST;
            kd_base    = pdmcs_pkg::KD_BASE_RST;
            kd_slope   = pdmcs_pkg::KD_SLOPE_RST;
            near_win   = pdmcs_pkg::NEAR_WIN_RST;
            alpha      = pdmcs_pkg::ALPHA_RST;
            frame_id   = pdmcs_pkg::FRAME_ID_RST;
            last_pos   = 16'h8000 >> POS_SHIFT;
            hold_pos   = 16'h8000 >> POS_SHIFT;
            vel_half   = 0;
            vel_avg    = 0;
            mismatches = 0;
        endfunction

        function void set_reg(pdmcs_pkg::t_cfg_idx k, logic [15:0] v);
            case (k)
                pdmcs_pkg::CFG_KP_FAR:   kp_far   = v[11:0];
                pdmcs_pkg::CFG_KP_NEAR:  kp_near  = v[11:0];
                pdmcs_pkg::CFG_KD_BASE:  kd_base  = v[11:0];
                pdmcs_pkg::CFG_KD_SLOPE: kd_slope = v[9:0];
                pdmcs_pkg::CFG_NEAR_WIN: near_win = v;
                pdmcs_pkg::CFG_ALPHA:    alpha    = v[8:0];
                pdmcs_pkg::CFG_FRAME_ID: frame_id = v[10:0];
                default: ;
            endcase
        endfunction

        function void take_request(pdmcs_pkg::t_req r, logic [63:0] rx);
            longint     a, vq, sum, mag, fabs_v, kd;
            logic [11:0] kp;
            t_cmd_frame f;
            case (r)
                pdmcs_pkg::REQ_REPLY: begin
                    last_pos = rx[55:40] >> POS_SHIFT;
                    vel_half = 2 * int'(rx[39:28]) - 4095;
                end
                pdmcs_pkg::REQ_HOME: begin
                    hold_pos = last_pos;
                end
                pdmcs_pkg::REQ_ENABLE: begin
                    f.bytes  = pdmcs_pkg::ENABLE_FRAME;
                    f.std_id = frame_id;
                    pending_frames.push_back(f);
                end
                default: begin
                    a        = (alpha > pdmcs_pkg::ALPHA_ONE) ?
                               longint'(pdmcs_pkg::ALPHA_ONE) : longint'(alpha);
                    vq       = longint'(vel_half) <<< pdmcs_pkg::VEL_FRAC_BITS_DEF;
                    sum      = a * vq + (256 - a) * vel_avg + 128;
                    vel_avg  = sum >>> 8;
                    mag      = longint'(hold_pos) - longint'(last_pos);
                    if (mag < 0) begin
                        mag = -mag;
                    end
                    kp       = (mag < longint'(near_win)) ? kp_near : kp_far;
                    fabs_v   = (vel_avg < 0) ? -vel_avg : vel_avg;
                    kd       = longint'(kd_base) + ((longint'(kd_slope) * fabs_v) >>> KD_SHIFT);
                    if (kd > longint'(pdmcs_pkg::KD_MAX)) begin
                        kd = longint'(pdmcs_pkg::KD_MAX);
                    end
                    f.bytes  = {16'(hold_pos << POS_SHIFT), pdmcs_pkg::ZERO_CODE12, kp,
                                12'(kd), pdmcs_pkg::ZERO_CODE12};
                    f.std_id = frame_id;
                    pending_frames.push_back(f);
                end
            endcase
        endfunction

        function void check_frame(logic [79:0] got);
            t_cmd_frame f;
            if (pending_frames.size() == 0) begin
                $display("%0t: unexpected frame %h", $time, got);
                mismatches++;
                return;
            end
            f = pending_frames.pop_front();
            if (got[63:0] !== f.bytes) begin
                $display("%0t: frame bytes expected %h actual %h", $time, f.bytes, got[63:0]);
                mismatches++;
            end
            if (got[74:64] !== f.std_id) begin
                $display("%0t: frame id expected %h actual %h", $time, f.std_id, got[74:64]);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_valid   = 1'b0;
    logic [63:0]          s_data    = '0;
    pdmcs_pkg::t_req      s_user    = pdmcs_pkg::REQ_REPLY;
    logic                 m_ready   = 1'b0;
    logic                 cfg_valid = 1'b0;
    pdmcs_pkg::t_cfg_idx  cfg_index = pdmcs_pkg::CFG_KP_FAR;
    logic [15:0]          cfg_data  = '0;
    logic                 calm      = 1'b0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [79:0] o_m_axis_tdata;
    logic        o_cfg_ready;

    command_frame_board board = new();

    pd_motor_command_scheduler_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        m_ready <= calm || ($urandom_range(99) >= 16);
    end

    // All inputs change only at the rising edge, so the values seen at the
    // falling edge are the ones the next rising edge will act on.
    always @(negedge clk) begin
        if (rst_n) begin
            if (cfg_valid && o_cfg_ready) begin
                board.set_reg(cfg_index, cfg_data);
            end
            if (s_valid && o_s_axis_tready) begin
                board.take_request(s_user, s_data);
            end
            if (o_m_axis_tvalid && m_ready) begin
                board.check_frame(o_m_axis_tdata);
            end
        end
    end

    task automatic send_request(pdmcs_pkg::t_req r, logic [63:0] d);
        while (!calm && $urandom_range(99) < 16) begin
            s_valid <= 1'b0;
            s_data  <= {$urandom, $urandom};
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= r;
        s_data  <= d;
        @(negedge clk);
        while (!o_s_axis_tready) begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    function automatic logic [63:0] reply_word(logic [15:0] p, logic [11:0] v);
        logic [63:0] w;
        w        = {$urandom, $urandom};
        w[55:40] = p;
        w[39:28] = v;
        return w;
    endfunction

    task automatic drain(int settle);
        s_valid <= 1'b0;
        while (board.pending_frames.size() != 0) begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    task automatic program_regs(int ph);
        pdmcs_pkg::t_cfg_idx k;
        logic [15:0]         v;
        k = k.first();
        do begin
            case (ph)
                1: v = '0;
                2: v = 16'hFFFF;
                6: v = 16'($urandom);
                default: begin
                    case (k)
                        pdmcs_pkg::CFG_KD_SLOPE: v = 16'($urandom_range(0, 1023));
                        pdmcs_pkg::CFG_NEAR_WIN: v = 16'($urandom_range(0, 300));
                        pdmcs_pkg::CFG_ALPHA: begin
                            if (ph == 3) begin
                                v = 16'(pdmcs_pkg::ALPHA_ONE);
                            end else if (ph == 5) begin
                                v = 16'($urandom_range(257, 511));
                            end else begin
                                v = 16'($urandom_range(0, 256));
                            end
                        end
                        pdmcs_pkg::CFG_FRAME_ID: v = 16'($urandom_range(0, 2047));
                        default: v = 16'($urandom_range(0, 4095));
                    endcase
                end
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= k;
            cfg_data  <= v;
            @(negedge clk);
            while (!o_cfg_ready) begin
                @(negedge clk);
            end
            @(posedge clk);
            k = k.next();
        end while (k != k.first());
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_items(int count);
        int          n;
        int          sel;
        logic [15:0] p;
        logic [11:0] v;
        n = 0;
        while (n < count) begin
            sel = $urandom_range(99);
            if (sel < 65) begin
                p = 16'(board.hold_pos << POS_SHIFT);
                if ($urandom_range(1)) begin
                    p = p + 16'($urandom_range(0, 600)) - 16'd300;
                end else begin
                    p = 16'($urandom);
                end
                case ($urandom_range(9))
                    0: v = 12'h000;
                    1: v = 12'hFFF;
                    default: v = 12'($urandom);
                endcase
                send_request(pdmcs_pkg::REQ_REPLY, reply_word(p, v));
                send_request(pdmcs_pkg::REQ_TICK, {$urandom, $urandom});
                n += 2;
            end else if (sel < 75) begin
                send_request(pdmcs_pkg::REQ_HOME, {$urandom, $urandom});
                n++;
            end else if (sel < 85) begin
                send_request(pdmcs_pkg::REQ_ENABLE, {$urandom, $urandom});
                n++;
            end else begin
                send_request(pdmcs_pkg::t_req'($urandom_range(3)), {$urandom, $urandom});
                n++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(pdmcs_pkg::REQ_ENABLE, '0);
        send_request(pdmcs_pkg::REQ_TICK, '1);
        send_request(pdmcs_pkg::REQ_REPLY, 64'h0);
        send_request(pdmcs_pkg::REQ_TICK, '0);
        send_request(pdmcs_pkg::REQ_HOME, '1);
        send_request(pdmcs_pkg::REQ_TICK, '0);
        send_request(pdmcs_pkg::REQ_REPLY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(pdmcs_pkg::REQ_TICK, '0);
        send_request(pdmcs_pkg::REQ_REPLY, reply_word(16'd39, 12'd2047));
        send_request(pdmcs_pkg::REQ_TICK, '0);
        send_request(pdmcs_pkg::REQ_REPLY, reply_word(16'd40, 12'd2048));
        send_request(pdmcs_pkg::REQ_TICK, '0);
        send_request(pdmcs_pkg::REQ_HOME, '0);
        send_request(pdmcs_pkg::REQ_REPLY, reply_word(16'd0, 12'd4095));
        send_request(pdmcs_pkg::REQ_TICK, '0);
        send_request(pdmcs_pkg::REQ_REPLY, reply_word(16'd1, 12'd0));
        send_request(pdmcs_pkg::REQ_TICK, '0);
        send_request(pdmcs_pkg::REQ_REPLY, reply_word(16'd79, 12'd2048));
        send_request(pdmcs_pkg::REQ_TICK, '0);
        send_request(pdmcs_pkg::REQ_REPLY, reply_word(16'd80, 12'd2047));
        send_request(pdmcs_pkg::REQ_TICK, '0);
        send_request(pdmcs_pkg::REQ_ENABLE, '1);
        random_items(100);

        for (int ph = 1; ph < 8; ph++) begin
            drain(10);
            program_regs(ph);
            calm = (ph == 4);
            random_items(230);
        end
        calm = 1'b0;
        drain(16);

        if (board.mismatches == 0 && board.pending_frames.size() == 0) begin
            $display("pd_motor_command_scheduler_top verification clean");
        end else begin
            $display("pd_motor_command_scheduler_top verification failed");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("pd_motor_command_scheduler_top verification failed");
        $finish;
    end

endmodule

`default_nettype wire

/* pd_motor_command_scheduler_top.f */
sv/pdmcs_pkg.sv
sv/pdmcs_cfg.sv
sv/pdmcs_ctrl.sv
sv/pdmcs_dp.sv
sv/pd_motor_command_scheduler_top.sv
sv/pdmcs_checker.sv
test/testbench.sv
